/* rtl/psa_pkg.sv */
`default_nettype none
package psa_pkg;

	localparam int BUCKETS_DEF    = 129;
	localparam int PAGE_SHIFT_DEF = 13;
	localparam int POOL_PAGES_DEF = 4096;

	localparam int KIND_W      = 2;
	localparam int CNT_W       = 8;
	localparam int PAGE_W      = 35;
	localparam int ADDR_W      = 48;
	localparam int STAT_W      = 2;
	localparam int LEN_OUT_W   = 8;
	localparam int CHUNK_CNT_W = 6;
	localparam int CFG_IDX_W   = 1;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNKS = 1'd1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK,
		STAT_OOM,
		STAT_NF,
		STAT_BAD
	} stat_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_REFILL, S_POP, S_SPLIT, S_BUSY,
		S_UL_RD, S_UL_FIX, S_LB_WR, S_MAP, S_PUSH_RD, S_PUSH_WR, S_PUSH_LINK,
		S_REL_CHK, S_BK0, S_BK_E, S_BK_CHK, S_FW0, S_FW_E, S_FW_CHK, S_RFORM,
		S_LK_E, S_LK_SET, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_TAKE, OP_SCAN, OP_REFILL, OP_HEAD_RD, OP_POP,
		OP_UL_RD, OP_UL_FIX, OP_SPLIT_SET, OP_BUSY_SET, OP_LB_WR, OP_MAP,
		OP_PUSH_RD, OP_PUSH_WR, OP_PUSH_LINK, OP_REL_RD, OP_REL_CHK, OP_BK_RD,
		OP_NB_RD, OP_BK_MERGE, OP_FW_RD, OP_FW_MERGE, OP_REL_FORM, OP_LK_RD,
		OP_LK_LEN, OP_LK_SET
	} op_t;

	typedef struct packed {
		op_t   op;
		logic  out_load;
		stat_t res;
	} cmd_t;

	typedef struct packed {
		logic              clr_last;
		logic [KIND_W-1:0] kind;
		logic              cnt_bad;
		logic              rel_oob;
		logic              lk_oob;
		logic              scan_hit;
		logic              scan_end;
		logic              refill_ok;
		logic              split;
		logic              not_start;
		logic              span_free;
		logic              at_zero;
		logic              e_zero;
		logic              nb_stop;
		logic              fw_end;
		logic              map_last;
		logic              fbusy;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/psa_req_if.sv */
`default_nettype none
interface psa_req_if;
	import psa_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [CNT_W-1:0]    page_count;
	logic [PAGE_W-1:0]   page_number;
	logic [ADDR_W-1:0]   address;
	modport source (output valid, kind, page_count, page_number, address, input ready);
	modport sink (input valid, kind, page_count, page_number, address, output ready);
endinterface
`default_nettype wire

/* rtl/psa_rsp_if.sv */
`default_nettype none
interface psa_rsp_if;
	import psa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [PAGE_W-1:0]    span_start;
	logic [LEN_OUT_W-1:0] span_length;
	modport source (output valid, status, span_start, span_length, input ready);
	modport sink (input valid, status, span_start, span_length, output ready);
endinterface
`default_nettype wire

/* rtl/psa_cfg_if.sv */
`default_nettype none
interface psa_cfg_if;
	import psa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [PAGE_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/psa_ram.sv */
`default_nettype none
module psa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/psa_ctrl.sv */
`default_nettype none
module psa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire psa_pkg::sts_t sts,
	output psa_pkg::cmd_t      cmd
);
	import psa_pkg::*;

	state_t state_q, state_n;
	state_t fret_q, fret_n;
	state_t uret_q, uret_n;
	stat_t  res_q, res_n;
	logic   out_valid_q, out_valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			fret_q      <= S_IDLE;
			uret_q      <= S_IDLE;
			res_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			fret_q      <= fret_n;
			uret_q      <= uret_n;
			res_q       <= res_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n      = state_q;
		fret_n       = fret_q;
		uret_n       = uret_q;
		res_n        = res_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		cmd.res      = res_q;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_TAKE;
					state_n = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.kind)
					KIND_ALLOC: begin
						if (sts.cnt_bad) begin
							res_n   = STAT_BAD;
							state_n = S_DONE;
						end else begin
							state_n = S_SCAN;
						end
					end
					KIND_RELEASE: begin
						if (sts.rel_oob) begin
							res_n   = STAT_NF;
							state_n = S_DONE;
						end else begin
							cmd.op  = OP_REL_RD;
							state_n = S_REL_CHK;
						end
					end
					KIND_LOOKUP: begin
						if (sts.lk_oob) begin
							res_n   = STAT_NF;
							state_n = S_DONE;
						end else begin
							cmd.op  = OP_LK_RD;
							state_n = S_LK_E;
						end
					end
					default: begin
						res_n   = STAT_BAD;
						state_n = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					cmd.op  = OP_HEAD_RD;
					state_n = S_POP;
				end else if (sts.scan_end) begin
					state_n = S_REFILL;
				end else begin
					cmd.op = OP_SCAN;
				end
			end
			S_REFILL: begin
				if (sts.refill_ok) begin
					cmd.op  = OP_REFILL;
					fret_n  = S_SCAN;
					state_n = S_LB_WR;
				end else begin
					res_n   = STAT_OOM;
					state_n = S_DONE;
				end
			end
			S_POP: begin
				cmd.op  = OP_POP;
				uret_n  = S_SPLIT;
				state_n = S_UL_RD;
			end
			S_SPLIT: begin
				if (sts.split) begin
					cmd.op  = OP_SPLIT_SET;
					fret_n  = S_BUSY;
					state_n = S_LB_WR;
				end else begin
					state_n = S_BUSY;
				end
			end
			S_BUSY: begin
				cmd.op  = OP_BUSY_SET;
				res_n   = STAT_OK;
				fret_n  = S_DONE;
				state_n = S_LB_WR;
			end
			S_UL_RD: begin
				cmd.op  = OP_UL_RD;
				state_n = S_UL_FIX;
			end
			S_UL_FIX: begin
				cmd.op  = OP_UL_FIX;
				state_n = uret_q;
			end
			S_LB_WR: begin
				cmd.op  = OP_LB_WR;
				state_n = S_MAP;
			end
			S_MAP: begin
				cmd.op = OP_MAP;
				if (sts.map_last) state_n = sts.fbusy ? fret_q : S_PUSH_RD;
			end
			S_PUSH_RD: begin
				cmd.op  = OP_PUSH_RD;
				state_n = S_PUSH_WR;
			end
			S_PUSH_WR: begin
				cmd.op  = OP_PUSH_WR;
				state_n = S_PUSH_LINK;
			end
			S_PUSH_LINK: begin
				cmd.op  = OP_PUSH_LINK;
				state_n = fret_q;
			end
			S_REL_CHK: begin
				if (sts.not_start) begin
					res_n   = STAT_NF;
					state_n = S_DONE;
				end else if (sts.span_free) begin
					res_n   = STAT_BAD;
					state_n = S_DONE;
				end else begin
					cmd.op  = OP_REL_CHK;
					state_n = S_BK0;
				end
			end
			S_BK0: begin
				if (sts.at_zero) begin
					state_n = S_FW0;
				end else begin
					cmd.op  = OP_BK_RD;
					state_n = S_BK_E;
				end
			end
			S_BK_E: begin
				if (sts.e_zero) begin
					state_n = S_FW0;
				end else begin
					cmd.op  = OP_NB_RD;
					state_n = S_BK_CHK;
				end
			end
			S_BK_CHK: begin
				if (sts.nb_stop) begin
					state_n = S_FW0;
				end else begin
					cmd.op  = OP_BK_MERGE;
					uret_n  = S_BK0;
					state_n = S_UL_RD;
				end
			end
			S_FW0: begin
				if (sts.fw_end) begin
					state_n = S_RFORM;
				end else begin
					cmd.op  = OP_FW_RD;
					state_n = S_FW_E;
				end
			end
			S_FW_E: begin
				if (sts.e_zero) begin
					state_n = S_RFORM;
				end else begin
					cmd.op  = OP_NB_RD;
					state_n = S_FW_CHK;
				end
			end
			S_FW_CHK: begin
				if (sts.nb_stop) begin
					state_n = S_RFORM;
				end else begin
					cmd.op  = OP_FW_MERGE;
					uret_n  = S_FW0;
					state_n = S_UL_RD;
				end
			end
			S_RFORM: begin
				cmd.op  = OP_REL_FORM;
				res_n   = STAT_OK;
				fret_n  = S_DONE;
				state_n = S_LB_WR;
			end
			S_LK_E: begin
				if (sts.e_zero) begin
					res_n   = STAT_NF;
					state_n = S_DONE;
				end else begin
					cmd.op  = OP_LK_LEN;
					state_n = S_LK_SET;
				end
			end
			S_LK_SET: begin
				cmd.op  = OP_LK_SET;
				res_n   = STAT_OK;
				state_n = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		out_valid_n = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_take_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DONE || state_q == S_DECODE)
		else $error("accepted request did not enter decode");
	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the done state");
`endif
endmodule
`default_nettype wire

/* rtl/psa_dpath.sv */
`default_nettype none
module psa_dpath #(
	parameter int BUCKETS    = psa_pkg::BUCKETS_DEF,
	parameter int PAGE_SHIFT = psa_pkg::PAGE_SHIFT_DEF,
	parameter int POOL_PAGES = psa_pkg::POOL_PAGES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire psa_pkg::cmd_t                     cmd,
	output psa_pkg::sts_t                          sts,
	input  wire logic [psa_pkg::KIND_W-1:0]        kind,
	input  wire logic [psa_pkg::CNT_W-1:0]         page_count,
	input  wire logic [psa_pkg::PAGE_W-1:0]        page_number,
	input  wire logic [psa_pkg::ADDR_W-1:0]        address,
	input  wire logic                              cfg_we,
	input  wire logic [psa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [psa_pkg::PAGE_W-1:0]        cfg_data,
	output logic      [psa_pkg::STAT_W-1:0]        status,
	output logic      [psa_pkg::PAGE_W-1:0]        span_start,
	output logic      [psa_pkg::LEN_OUT_W-1:0]     span_length
);
	import psa_pkg::*;

	localparam int AW    = $clog2(POOL_PAGES);
	localparam int EW    = $clog2(POOL_PAGES + 1);
	localparam int BW    = $clog2(BUCKETS);
	localparam int LW    = BW;
	localparam int SW    = (AW > LW ? AW : LW) + 1;
	localparam int CHUNK = BUCKETS - 1;
	localparam int CAP   = POOL_PAGES / CHUNK;

	logic [KIND_W-1:0]      kind_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [PAGE_W-1:0]      page_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [PAGE_W-1:0]      base_q;
	logic [CHUNK_CNT_W-1:0] chunks_q, cu_q;
	logic [AW-1:0]          clr_q, s_q, fs_q, us_q, q_q;
	logic [LW-1:0]          len_q, fl_q, i_q;
	logic [BW-1:0]          b_q, ub_q;
	logic [EW-1:0]          h_q;
	logic                   fbusy_q, pass_q;
	logic [BUCKETS-1:0]     ne_q;

	logic          om_we, om_re;
	logic [AW-1:0] om_waddr, om_raddr;
	logic [EW-1:0] om_wdata, om_rdata;
	logic          lb_we, lb_re;
	logic [AW-1:0] lb_waddr, lb_raddr;
	logic [LW:0]   lb_wdata, lb_rdata;
	logic          nx_we, nx_re, pv_we;
	logic [AW-1:0] nx_waddr, pv_waddr, lk_raddr;
	logic [EW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
	logic          hd_we, hd_re;
	logic [BW-1:0] hd_waddr, hd_raddr;
	logic [EW-1:0] hd_wdata, hd_rdata;

	logic [PAGE_W-1:0] rel_loc, lk_loc;
	logic [ADDR_W-1:0] lk_page;
	logic [LW-1:0]     lb_len;
	logic              lb_busy;
	logic [LW:0]       nb_sum;
	logic [SW-1:0]     map_pg, fw_pg;
	logic [EW-1:0]     h_new, fs_ptr;
	logic [AW-1:0]     hd_ptr, e_ptr;

	always_comb begin
		rel_loc = page_q - base_q;
		lk_page = addr_q >> PAGE_SHIFT;
		lk_loc  = lk_page[PAGE_W-1:0] - base_q;
		lb_len  = lb_rdata[LW:1];
		lb_busy = lb_rdata[0];
		nb_sum  = {1'b0, lb_len} + {1'b0, len_q};
		map_pg  = SW'(fs_q) + SW'(i_q);
		fw_pg   = SW'(s_q) + SW'(len_q);
		h_new   = ne_q[fl_q] ? hd_rdata : '0;
		fs_ptr  = EW'(fs_q) + EW'(1);
		hd_ptr  = AW'(hd_rdata - EW'(1));
		e_ptr   = AW'(om_rdata - EW'(1));
	end

	always_comb begin
		sts.clr_last  = (clr_q == AW'(POOL_PAGES - 1));
		sts.kind      = kind_q;
		sts.cnt_bad   = (cnt_q == '0) || (32'(cnt_q) >= BUCKETS);
		sts.rel_oob   = (rel_loc >= PAGE_W'(POOL_PAGES));
		sts.lk_oob    = (lk_loc >= PAGE_W'(POOL_PAGES));
		sts.scan_hit  = ne_q[b_q];
		sts.scan_end  = (b_q == BW'(BUCKETS - 1));
		sts.refill_ok = !pass_q && (cu_q < chunks_q) && (32'(cu_q) < CAP);
		sts.split     = (b_q > BW'(cnt_q));
		sts.not_start = (om_rdata != EW'(s_q) + EW'(1));
		sts.span_free = !lb_busy;
		sts.at_zero   = (s_q == '0);
		sts.e_zero    = (om_rdata == '0);
		sts.nb_stop   = lb_busy || (nb_sum >= (LW + 1)'(BUCKETS));
		sts.fw_end    = (fw_pg >= SW'(POOL_PAGES));
		sts.map_last  = ((LW + 1)'(i_q) + (LW + 1)'(1) >= (LW + 1)'(fl_q));
		sts.fbusy     = fbusy_q;
	end

	// memory port steering, one operation per cycle
	always_comb begin
		om_we = 1'b0; om_waddr = clr_q; om_wdata = '0;
		om_re = 1'b0; om_raddr = s_q;
		lb_we = 1'b0; lb_waddr = fs_q; lb_wdata = {fl_q, fbusy_q};
		lb_re = 1'b0; lb_raddr = e_ptr;
		nx_we = 1'b0; nx_waddr = fs_q; nx_wdata = h_new;
		pv_we = 1'b0; pv_waddr = fs_q; pv_wdata = '0;
		nx_re = 1'b0; lk_raddr = us_q;
		hd_we = 1'b0; hd_waddr = fl_q; hd_wdata = fs_ptr;
		hd_re = 1'b0; hd_raddr = b_q;
		case (cmd.op)
			OP_CLEAR: om_we = 1'b1;
			OP_MAP: begin
				om_we    = (map_pg < SW'(POOL_PAGES));
				om_waddr = AW'(map_pg);
				om_wdata = fs_ptr;
			end
			OP_REL_RD: begin
				om_re    = 1'b1;
				om_raddr = AW'(rel_loc);
				lb_re    = 1'b1;
				lb_raddr = AW'(rel_loc);
			end
			OP_BK_RD: begin
				om_re    = 1'b1;
				om_raddr = s_q - AW'(1);
			end
			OP_FW_RD: begin
				om_re    = 1'b1;
				om_raddr = AW'(fw_pg);
			end
			OP_LK_RD: begin
				om_re    = 1'b1;
				om_raddr = AW'(lk_loc);
			end
			OP_NB_RD, OP_LK_LEN: lb_re = 1'b1;
			OP_LB_WR: lb_we = 1'b1;
			OP_HEAD_RD: hd_re = 1'b1;
			OP_PUSH_RD: begin
				hd_re    = 1'b1;
				hd_raddr = fl_q;
			end
			OP_PUSH_WR: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
				hd_we = 1'b1;
			end
			OP_PUSH_LINK: begin
				pv_we    = (h_q != '0);
				pv_waddr = AW'(h_q - EW'(1));
				pv_wdata = fs_ptr;
			end
			OP_UL_RD: nx_re = 1'b1;
			OP_UL_FIX: begin
				nx_we    = (pv_rdata != '0);
				nx_waddr = AW'(pv_rdata - EW'(1));
				nx_wdata = nx_rdata;
				hd_we    = (pv_rdata == '0);
				hd_waddr = ub_q;
				hd_wdata = nx_rdata;
				pv_we    = (nx_rdata != '0);
				pv_waddr = AW'(nx_rdata - EW'(1));
				pv_wdata = pv_rdata;
			end
			default: ;
		endcase
	end

	psa_ram #(.WIDTH(EW), .DEPTH(POOL_PAGES)) u_owner (
		.clk(clk), .we(om_we), .waddr(om_waddr), .wdata(om_wdata),
		.re(om_re), .raddr(om_raddr), .rdata(om_rdata));
	psa_ram #(.WIDTH(LW + 1), .DEPTH(POOL_PAGES)) u_lenbusy (
		.clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
		.re(lb_re), .raddr(lb_raddr), .rdata(lb_rdata));
	psa_ram #(.WIDTH(EW), .DEPTH(POOL_PAGES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.re(nx_re), .raddr(lk_raddr), .rdata(nx_rdata));
	psa_ram #(.WIDTH(EW), .DEPTH(POOL_PAGES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.re(nx_re), .raddr(lk_raddr), .rdata(pv_rdata));
	psa_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.re(hd_re), .raddr(hd_raddr), .rdata(hd_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			chunks_q <= '0;
			cu_q     <= '0;
			clr_q    <= '0;
			ne_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE:   base_q   <= cfg_data;
					REG_CHUNKS: chunks_q <= cfg_data[CHUNK_CNT_W-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_CLEAR:   clr_q <= clr_q + AW'(1);
				OP_REFILL:  cu_q  <= cu_q + CHUNK_CNT_W'(1);
				OP_PUSH_WR: ne_q[fl_q] <= 1'b1;
				OP_UL_FIX:  if (pv_rdata == '0) ne_q[ub_q] <= (nx_rdata != '0);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TAKE: begin
				kind_q <= kind;
				cnt_q  <= page_count;
				page_q <= page_number;
				addr_q <= address;
				b_q    <= BW'(page_count);
				pass_q <= 1'b0;
			end
			OP_SCAN: b_q <= b_q + BW'(1);
			OP_REFILL: begin
				fs_q    <= AW'(cu_q * CHUNK);
				fl_q    <= LW'(CHUNK);
				fbusy_q <= 1'b0;
				pass_q  <= 1'b1;
				b_q     <= BW'(cnt_q);
			end
			OP_POP: begin
				s_q  <= hd_ptr;
				us_q <= hd_ptr;
				ub_q <= b_q;
			end
			OP_SPLIT_SET: begin
				fs_q    <= s_q + AW'(cnt_q);
				fl_q    <= LW'(b_q - BW'(cnt_q));
				fbusy_q <= 1'b0;
			end
			OP_BUSY_SET: begin
				fs_q    <= s_q;
				fl_q    <= LW'(cnt_q);
				fbusy_q <= 1'b1;
				len_q   <= LW'(cnt_q);
			end
			OP_LB_WR:   i_q <= '0;
			OP_MAP:     i_q <= i_q + LW'(1);
			OP_PUSH_WR: h_q <= h_new;
			OP_REL_RD:  s_q <= AW'(rel_loc);
			OP_REL_CHK: len_q <= lb_len;
			OP_NB_RD:   q_q <= e_ptr;
			OP_BK_MERGE: begin
				us_q  <= q_q;
				ub_q  <= BW'(lb_len);
				s_q   <= q_q;
				len_q <= len_q + lb_len;
			end
			OP_FW_MERGE: begin
				us_q  <= q_q;
				ub_q  <= BW'(lb_len);
				len_q <= len_q + lb_len;
			end
			OP_REL_FORM: begin
				fs_q    <= s_q;
				fl_q    <= len_q;
				fbusy_q <= 1'b0;
			end
			OP_LK_LEN: s_q <= e_ptr;
			OP_LK_SET: len_q <= lb_len;
			default: ;
		endcase
		if (cmd.out_load) begin
			status <= cmd.res;
			if (cmd.res == STAT_OK) begin
				span_start  <= base_q + PAGE_W'(s_q);
				span_length <= LEN_OUT_W'(len_q);
			end else begin
				span_start  <= '0;
				span_length <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_chunks_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cu_q) <= CAP)
		else $error("chunk count ran past pool capacity");
	a_push_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PUSH_WR |=> ne_q[fl_q])
		else $error("pushed bucket not marked nonempty");
`endif
endmodule
`default_nettype wire

/* rtl/page_span_allocator_unit.sv */
`default_nettype none
// Channel | Dir | Beat contents
// req     | in  | kind, page_count, page_number, address
// rsp     | out | status, span_start, span_length
// cfg     | in  | index (0 pool_base_page, 1 pool_chunks), data
//
// Sequencing: one request at a time through the controller; a lookup reads
// the owner map and then the span table before its result beat, an allocate
// makes up to two bucket scans, a refill map fill of BUCKETS-1 pages and a
// split map fill, and a release merges each free neighbor in turn and ends
// with a map fill of the freed span.
// Reset: a clearing pass walks the whole owner map before req is ready;
// cfg writes are taken throughout.
// Stalls: the result register holds a beat while rsp.ready is low and the
// next request waits in the done step only if that register is still full.
module page_span_allocator_unit #(
	parameter int BUCKETS    = psa_pkg::BUCKETS_DEF,
	parameter int PAGE_SHIFT = psa_pkg::PAGE_SHIFT_DEF,
	parameter int POOL_PAGES = psa_pkg::POOL_PAGES_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	psa_req_if.sink   req,
	psa_rsp_if.source rsp,
	psa_cfg_if.sink   cfg
);
	import psa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// config registers accept every beat
	assign cfg.ready = 1'b1;

	// sequencer: decides each step from datapath status
	psa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: free lists, owner map, span table and result register
	psa_dpath #(
		.BUCKETS   (BUCKETS),
		.PAGE_SHIFT(PAGE_SHIFT),
		.POOL_PAGES(POOL_PAGES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (req.kind),
		.page_count (req.page_count),
		.page_number(req.page_number),
		.address    (req.address),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.status     (rsp.status),
		.span_start (rsp.span_start),
		.span_length(rsp.span_length)
	);
endmodule
`default_nettype wire
